// File: rtl/bilinear_image_resampler_top_defines.svh
// Assertion macros shared by the resampler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BILINEAR_IMAGE_RESAMPLER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_RESAMPLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check sampled on clk, ignored while rst_n is low
`define BIR_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// check sampled on clk at every edge
`define BIR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define BIR_ASSERT_RST(label, clk, rst_n, prop)
`define BIR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/bir_pkg.sv
// Shared constants, types and codes of the bilinear resampler.
// No dependencies.
package bir_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int PIXEL_BITS    = 16;
    localparam int FRAC_BITS     = 16;
    localparam int COORD_BITS    = 12;
    localparam int SIZE_BITS     = 9;
    localparam int STEP_BITS     = 24;
    localparam int POS_BITS      = COORD_BITS + STEP_BITS;
    localparam int IDX_BITS      = POS_BITS - FRAC_BITS;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int MEM_ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int MEM_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    // blend widths: horizontal sum, vertical difference and product
    localparam int HORZ_BITS     = PIXEL_BITS + FRAC_BITS + 2;
    localparam int VDIFF_BITS    = HORZ_BITS + 1;
    localparam int VPROD_BITS    = VDIFF_BITS + FRAC_BITS + 1;
    localparam int IPART_BITS    = VPROD_BITS - 2 * FRAC_BITS;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(256);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_STEP_X        = 2'd2,
        REG_STEP_Y        = 2'd3
    } t_reg_idx;

    // input operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // neighbor select: row then column offset
    typedef enum logic [1:0] {
        NB_00 = 2'd0,
        NB_01 = 2'd1,
        NB_10 = 2'd2,
        NB_11 = 2'd3
    } t_nbr;

    typedef struct packed {
        logic [SIZE_BITS-1:0] source_width;
        logic [SIZE_BITS-1:0] source_height;
        logic [STEP_BITS-1:0] step_x;
        logic [STEP_BITS-1:0] step_y;
    } t_cfg;

    typedef struct packed {
        logic accept;    // input operation (write or request) taken this cycle
        logic map;       // coord * step
        logic clamp;     // neighbor indices and weights
        logic rd_en;     // image read at rd_sel
        t_nbr rd_sel;
        logic cap_en;    // capture read data into cap_sel
        t_nbr cap_sel;
        logic horz;      // blend along x
        logic vert;      // blend difference along y
        logic sum;       // final exact sum
        logic load_out;  // round and load result register
    } t_cmd;

    typedef struct packed {
        logic out_busy;  // result register full and not taken
    } t_sts;

endpackage

// File: rtl/bir_regs.sv
// APB register file of the resampler: size and step registers.
// Depends on bir_pkg.
module bir_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bir_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bir_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bir_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output bir_pkg::t_cfg                      o_cfg
);
    import bir_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= SIZE_RESET;
            r_cfg.source_height <= SIZE_RESET;
            r_cfg.step_x        <= STEP_RESET;
            r_cfg.step_y        <= STEP_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_SOURCE_WIDTH:  r_cfg.source_width  <= pwdata[SIZE_BITS-1:0];
                REG_SOURCE_HEIGHT: r_cfg.source_height <= pwdata[SIZE_BITS-1:0];
                REG_STEP_X:        r_cfg.step_x        <= pwdata[STEP_BITS-1:0];
                REG_STEP_Y:        r_cfg.step_y        <= pwdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SOURCE_WIDTH:  prdata = APB_DATA_BITS'(r_cfg.source_width);
            REG_SOURCE_HEIGHT: prdata = APB_DATA_BITS'(r_cfg.source_height);
            REG_STEP_X:        prdata = APB_DATA_BITS'(r_cfg.step_x);
            REG_STEP_Y:        prdata = APB_DATA_BITS'(r_cfg.step_y);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/bir_ctrl.sv
// Sequencer of the resampler: input handshake and per-request step order.
// Depends on bir_pkg and the assertion macro header.
`include "bilinear_image_resampler_top_defines.svh"
module bir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_operation,
    output logic          o_in_ready,
    input  bir_pkg::t_sts i_sts,
    output bir_pkg::t_cmd o_cmd
);
    import bir_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MAP   = 12'b0000_0000_0010,
        S_CLAMP = 12'b0000_0000_0100,
        S_RD00  = 12'b0000_0000_1000,
        S_RD01  = 12'b0000_0001_0000,
        S_RD10  = 12'b0000_0010_0000,
        S_RD11  = 12'b0000_0100_0000,
        S_WAIT  = 12'b0000_1000_0000,
        S_HORZ  = 12'b0001_0000_0000,
        S_VERT  = 12'b0010_0000_0000,
        S_SUM   = 12'b0100_0000_0000,
        S_ROUND = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.accept = accept;
                if (accept && (i_operation == OP_REQUEST)) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                cmd.map = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp = 1'b1;
                n_state   = S_RD00;
            end
            S_RD00: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = NB_00;
                n_state    = S_RD01;
            end
            S_RD01: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_01;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_00;
                n_state     = S_RD10;
            end
            S_RD10: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_10;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_01;
                n_state     = S_RD11;
            end
            S_RD11: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_11;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_10;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_11;
                n_state     = S_HORZ;
            end
            S_HORZ: begin
                cmd.horz = 1'b1;
                n_state  = S_VERT;
            end
            S_VERT: begin
                cmd.vert = 1'b1;
                n_state  = S_SUM;
            end
            S_SUM: begin
                // product of the vertical step is registered now
                cmd.sum = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // hold until the result slot frees
                if (!i_sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

    `BIR_ASSERT_RST(a_load_needs_slot, i_clk, i_rst_n, o_cmd.load_out |-> !i_sts.out_busy)
    `BIR_ASSERT_RST(a_req_starts_map, i_clk, i_rst_n, (accept && (i_operation == OP_REQUEST)) |=> (r_state == S_MAP))
    `BIR_ASSERT_RST(a_no_read_while_ready, i_clk, i_rst_n, o_in_ready |-> !o_cmd.rd_en)

endmodule

// File: rtl/bir_dp.sv
// Datapath of the resampler: image memory, mapping, clamp, blend, rounding
// and the result register. Depends on bir_pkg.
module bir_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bir_pkg::t_cfg                       i_cfg,
    input  bir_pkg::t_cmd                       i_cmd,
    output bir_pkg::t_sts                       o_sts,
    input  logic                                i_operation,
    input  logic [bir_pkg::COORD_BITS-1:0]      i_coord_x,
    input  logic [bir_pkg::COORD_BITS-1:0]      i_coord_y,
    input  logic signed [bir_pkg::PIXEL_BITS-1:0] i_pixel_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bir_pkg::PIXEL_BITS-1:0] o_pixel_out
);
    import bir_pkg::*;

    function automatic logic [SIZE_BITS-1:0] limit_size(input logic [SIZE_BITS-1:0] s,
                                                        input logic [SIZE_BITS-1:0] maxv);
        logic [SIZE_BITS-1:0] v;
        if (s < SIZE_BITS'(2)) v = SIZE_BITS'(2);
        else if (s > maxv)     v = maxv;
        else                   v = s;
        return v;
    endfunction

    function automatic logic [SIZE_BITS-1:0] clamp_idx(input logic [IDX_BITS:0]    idx,
                                                       input logic [SIZE_BITS-1:0] last);
        logic [SIZE_BITS-1:0] v;
        if (idx >= (IDX_BITS+1)'(last)) v = last;
        else                            v = idx[SIZE_BITS-1:0];
        return v;
    endfunction

    // image store
    logic signed [PIXEL_BITS-1:0] mem [0:MEM_DEPTH-1];
    logic signed [PIXEL_BITS-1:0] r_rd;
    logic [MEM_ADDR_BITS-1:0]     mem_addr, rd_addr;
    logic                         mem_we, wr_in_range;

    logic [COORD_BITS-1:0]        r_cx, r_cy;
    logic [POS_BITS-1:0]          r_px, r_py;
    logic [COL_BITS-1:0]          r_x0, r_x1;
    logic [ROW_BITS-1:0]          r_y0, r_y1;
    logic [FRAC_BITS-1:0]         r_fx, r_fy;
    logic signed [PIXEL_BITS-1:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [HORZ_BITS-1:0]  r_top, r_bot;
    logic signed [VPROD_BITS-1:0] r_vprod, r_sum;
    logic                         r_out_valid;
    logic signed [PIXEL_BITS-1:0] r_pixel_out;

    // clamp stage
    logic [SIZE_BITS-1:0]         w_last, h_last, x0_c, x1_c, y0_c, y1_c;
    logic [IDX_BITS-1:0]          ix, iy;

    // blend stages
    logic signed [PIXEL_BITS:0]   d_top, d_bot;
    logic signed [FRAC_BITS:0]    fx_s, fy_s;
    logic signed [HORZ_BITS-1:0]  m_top, m_bot, n_top, n_bot;
    logic signed [HORZ_BITS-1:0]  base00, base10;
    logic signed [VDIFF_BITS-1:0] d_vert;
    logic signed [VPROD_BITS-1:0] n_vprod, top_ext, n_sum;

    // rounding
    logic signed [IPART_BITS-1:0] ipart, rounded;
    logic [2*FRAC_BITS-1:0]       frac, half;
    logic                         inc;

    assign wr_in_range = (i_coord_x < COORD_BITS'(MAX_WIDTH))
                       && (i_coord_y < COORD_BITS'(MAX_HEIGHT));
    assign mem_we      = i_cmd.accept && (i_operation == OP_WRITE) && wr_in_range;

    always_comb begin
        unique case (i_cmd.rd_sel)
            NB_00:   rd_addr = {r_y0, r_x0};
            NB_01:   rd_addr = {r_y0, r_x1};
            NB_10:   rd_addr = {r_y1, r_x0};
            NB_11:   rd_addr = {r_y1, r_x1};
            default: rd_addr = {r_y0, r_x0};
        endcase
    end

    assign mem_addr = i_cmd.rd_en ? rd_addr
                                  : {i_coord_y[ROW_BITS-1:0], i_coord_x[COL_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_pixel_in;
        end
        r_rd <= mem[mem_addr];
    end

    // clamp indices
    always_comb begin
        w_last = limit_size(i_cfg.source_width,  SIZE_BITS'(MAX_WIDTH))  - SIZE_BITS'(1);
        h_last = limit_size(i_cfg.source_height, SIZE_BITS'(MAX_HEIGHT)) - SIZE_BITS'(1);
        ix     = r_px[POS_BITS-1:FRAC_BITS];
        iy     = r_py[POS_BITS-1:FRAC_BITS];
        x0_c   = clamp_idx({1'b0, ix}, w_last);
        x1_c   = clamp_idx({1'b0, ix} + (IDX_BITS+1)'(1), w_last);
        y0_c   = clamp_idx({1'b0, iy}, h_last);
        y1_c   = clamp_idx({1'b0, iy} + (IDX_BITS+1)'(1), h_last);
    end

    // horizontal blend: p0*R + (p1 - p0)*fx
    always_comb begin
        fx_s   = $signed({1'b0, r_fx});
        fy_s   = $signed({1'b0, r_fy});
        d_top  = $signed({r_p01[PIXEL_BITS-1], r_p01}) - $signed({r_p00[PIXEL_BITS-1], r_p00});
        d_bot  = $signed({r_p11[PIXEL_BITS-1], r_p11}) - $signed({r_p10[PIXEL_BITS-1], r_p10});
        m_top  = HORZ_BITS'(d_top) * HORZ_BITS'(fx_s);
        m_bot  = HORZ_BITS'(d_bot) * HORZ_BITS'(fx_s);
        base00 = HORZ_BITS'(r_p00);
        base10 = HORZ_BITS'(r_p10);
        n_top  = (base00 <<< FRAC_BITS) + m_top;
        n_bot  = (base10 <<< FRAC_BITS) + m_bot;
        // vertical: top*R + (bot - top)*fy
        d_vert  = VDIFF_BITS'(r_bot) - VDIFF_BITS'(r_top);
        n_vprod = VPROD_BITS'(d_vert) * VPROD_BITS'(fy_s);
        top_ext = VPROD_BITS'(r_top);
        n_sum   = (top_ext <<< FRAC_BITS) + r_vprod;
    end

    // round half away from zero on the R^2 scale
    always_comb begin
        ipart   = r_sum[VPROD_BITS-1:2*FRAC_BITS];
        frac    = r_sum[2*FRAC_BITS-1:0];
        half    = {1'b1, {(2*FRAC_BITS-1){1'b0}}};
        inc     = ipart[IPART_BITS-1] ? (frac > half) : (frac >= half);
        rounded = ipart + $signed({{(IPART_BITS-1){1'b0}}, inc});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
        if (i_cmd.map) begin
            r_px <= POS_BITS'(r_cx) * POS_BITS'(i_cfg.step_x);
            r_py <= POS_BITS'(r_cy) * POS_BITS'(i_cfg.step_y);
        end
        if (i_cmd.clamp) begin
            r_x0 <= x0_c[COL_BITS-1:0];
            r_x1 <= x1_c[COL_BITS-1:0];
            r_y0 <= y0_c[ROW_BITS-1:0];
            r_y1 <= y1_c[ROW_BITS-1:0];
            r_fx <= r_px[FRAC_BITS-1:0];
            r_fy <= r_py[FRAC_BITS-1:0];
        end
        if (i_cmd.cap_en) begin
            unique case (i_cmd.cap_sel)
                NB_00:   r_p00 <= r_rd;
                NB_01:   r_p01 <= r_rd;
                NB_10:   r_p10 <= r_rd;
                NB_11:   r_p11 <= r_rd;
                default: r_p00 <= r_rd;
            endcase
        end
        if (i_cmd.horz) begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
        if (i_cmd.vert) begin
            r_vprod <= n_vprod;
        end
        if (i_cmd.sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.load_out) begin
            r_pixel_out <= rounded[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_pixel_out;

endmodule

// File: rtl/bilinear_image_resampler_top.sv
// Top level of the bilinear image resampler.
// Depends on bir_pkg, bir_regs, bir_ctrl and bir_dp.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  input    | in        | i_in_valid / o_in_ready | i_operation, i_coord_x/y, i_pixel_in
//  result   | out       | o_out_valid/i_out_ready | o_pixel_out
//  config   | in        | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// Pixel writes can stream at one per clock while no request is in flight.
// A request loads the result register after map, clamp, four single-port reads
// plus read latency, two blends, sum and round; ready is low meanwhile, so the
// next request or write is taken only once the previous request is through.
// A pending result does not block writes; a request waits in rounding while
// the previous result is untaken. Reset is synchronous, active low; memory not cleared.
module bilinear_image_resampler_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_operation,
    input  logic [bir_pkg::COORD_BITS-1:0]        i_coord_x,
    input  logic [bir_pkg::COORD_BITS-1:0]        i_coord_y,
    input  logic signed [bir_pkg::PIXEL_BITS-1:0] i_pixel_in,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bir_pkg::PIXEL_BITS-1:0] o_pixel_out,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bir_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [bir_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [bir_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready
);
    import bir_pkg::*;

    t_cfg cfg;   // register contents; keep stable while a request is in flight (not enforced)
    t_cmd cmd;   // sequencer step commands
    t_sts sts;   // datapath status back to the sequencer

    bir_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bir_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out)
    );

endmodule
